// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file skq_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// File: sv/skq_pkg.sv
// ----------------------------------------------------------------------------
// skq_pkg
// Types and constants of the sorted key queue.
// ----------------------------------------------------------------------------
`default_nettype none

package skq_pkg;

    localparam int KEY_W  = 16;
    localparam int PAY_W  = 32;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT      = 2'd0,
        CMD_REMOVE_HEAD = 2'd1,
        CMD_REMOVE_KEY  = 2'd2,
        CMD_PREPEND     = 2'd3
    } cmd_code_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_code_t;

    localparam logic signed [KEY_W-1:0] KEY_MIN        = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_FIRST      = KEY_W'(1);

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } entry_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE        = 4'd0,
        OP_LOAD        = 4'd1,
        OP_SET_FULL    = 4'd2,
        OP_SET_EMPTY   = 4'd3,
        OP_SET_MISS    = 4'd4,
        OP_INIT_UP     = 4'd5,
        OP_UP_MOVE     = 4'd6,
        OP_PUT_NEW     = 4'd7,
        OP_INIT_SEARCH = 4'd8,
        OP_SEARCH_NEXT = 4'd9,
        OP_HIT         = 4'd10,
        OP_DN_MOVE     = 4'd11,
        OP_DN_DONE     = 4'd12,
        OP_EMIT        = 4'd13
    } dp_op_t;

    typedef struct packed {
        logic is_add;
        logic full;
        logic empty;
        logic idx_zero;
        logic last;
        logic move;
        logic match;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: sv/skq_if.sv
// ----------------------------------------------------------------------------
// skq_if
// Request and response channels of the sorted key queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface skq_req_if import skq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic signed [KEY_W-1:0] in_key;
    logic [PAY_W-1:0]        in_payload;

    modport source (output valid, output command, output in_key, output in_payload,
                    input ready);
    modport sink   (input valid, input command, input in_key, input in_payload,
                    output ready);
endinterface

interface skq_rsp_if import skq_pkg::*; #(parameter int COUNT_W = 5) ();
    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic signed [KEY_W-1:0] out_key;
    logic [PAY_W-1:0]        out_payload;
    logic [COUNT_W-1:0]      entry_count;

    modport source (output valid, output status, output out_key, output out_payload,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input out_key, input out_payload,
                    input entry_count, output ready);
endinterface

`default_nettype wire

// File: sv/skq_ctrl.sv
// ----------------------------------------------------------------------------
// skq_ctrl
// Command sequencer: walks one word through the entry store at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module skq_ctrl import skq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_op_t   op
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_START   = 6'b000010,
        S_WALK_UP = 6'b000100,
        S_SEARCH  = 6'b001000,
        S_WALK_DN = 6'b010000,
        S_FINISH  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (stat.is_add)
                begin
                    if (stat.full)
                    begin
                        op         = OP_SET_FULL;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        op         = OP_INIT_UP;
                        state_next = S_WALK_UP;
                    end
                end
                else if (stat.empty)
                begin
                    op         = OP_SET_EMPTY;
                    state_next = S_FINISH;
                end
                else
                begin
                    op         = OP_INIT_SEARCH;
                    state_next = S_SEARCH;
                end
            end
            S_WALK_UP:
            begin
                // stop at the bottom slot or at the first key not above the new one
                if (stat.idx_zero || !stat.move)
                begin
                    op         = OP_PUT_NEW;
                    state_next = S_FINISH;
                end
                else
                begin
                    op = OP_UP_MOVE;
                end
            end
            S_SEARCH:
            begin
                priority if (stat.match)
                begin
                    op         = OP_HIT;
                    state_next = S_WALK_DN;
                end
                else if (stat.last)
                begin
                    op         = OP_SET_MISS;
                    state_next = S_FINISH;
                end
                else
                begin
                    op = OP_SEARCH_NEXT;
                end
            end
            S_WALK_DN:
            begin
                if (stat.last)
                begin
                    op         = OP_DN_DONE;
                    state_next = S_FINISH;
                end
                else
                begin
                    op = OP_DN_MOVE;
                end
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (op == OP_EMIT)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: sv/skq_dp.sv
// ----------------------------------------------------------------------------
// skq_dp
// Entry store, walk index, compare logic and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module skq_dp import skq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [CMD_W-1:0]         in_command,
    input  logic signed [KEY_W-1:0]  in_key,
    input  logic [PAY_W-1:0]         in_payload,
    input  dp_op_t                   op,
    output dp_stat_t                 stat,
    output logic [STAT_W-1:0]        out_status,
    output logic signed [KEY_W-1:0]  out_key,
    output logic [PAY_W-1:0]         out_payload,
    output logic [$clog2(CAPACITY+1)-1:0] out_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    entry_t entry_mem [CAPACITY];
    entry_t rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    entry_t           wr_data;

    cmd_code_t               cmd_reg,        cmd_next;
    logic signed [KEY_W-1:0] key_reg,        key_next;
    logic [PAY_W-1:0]        pay_reg,        pay_next;
    logic [CNT_W-1:0]        count_reg,      count_next;
    logic [IDX_W-1:0]        idx_reg,        idx_next;
    status_code_t            res_status_reg, res_status_next;
    logic signed [KEY_W-1:0] res_key_reg,    res_key_next;
    logic [PAY_W-1:0]        res_pay_reg,    res_pay_next;
    logic [STAT_W-1:0]       out_status_reg, out_status_next;
    logic signed [KEY_W-1:0] out_key_reg,    out_key_next;
    logic [PAY_W-1:0]        out_pay_reg,    out_pay_next;
    logic [CNT_W-1:0]        out_count_reg,  out_count_next;

    logic signed [KEY_W-1:0] prep_key;

    // one below the head key, pinned at the minimum
    assign prep_key = (rd_data_reg.key == KEY_MIN) ? KEY_MIN : rd_data_reg.key - KEY_FIRST;

    always_comb
    begin
        stat.is_add   = (cmd_reg == CMD_INSERT) || (cmd_reg == CMD_PREPEND);
        stat.full     = (count_reg == CNT_W'(CAPACITY));
        stat.empty    = (count_reg == '0);
        stat.idx_zero = (idx_reg == '0);
        stat.last     = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
        stat.move     = (cmd_reg == CMD_PREPEND) || (rd_data_reg.key > key_reg);
        stat.match    = (cmd_reg == CMD_REMOVE_HEAD) || (rd_data_reg.key == key_reg);
    end

    // read one slot ahead of the walk so its word is registered when needed
    always_comb
    begin
        unique case (op)
            OP_INIT_UP:                rd_addr = IDX_W'(count_reg - CNT_W'(1));
            OP_UP_MOVE:                rd_addr = idx_reg - IDX_W'(2);
            OP_HIT, OP_SEARCH_NEXT:    rd_addr = idx_reg + IDX_W'(1);
            OP_DN_MOVE:                rd_addr = idx_reg + IDX_W'(2);
            default:                   rd_addr = '0;
        endcase
    end

    assign wr_en   = (op == OP_PUT_NEW) || (op == OP_UP_MOVE) || (op == OP_DN_MOVE);
    assign wr_data = (op == OP_PUT_NEW) ? entry_t'{key: key_reg, payload: pay_reg}
                                        : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[idx_reg] <= wr_data;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    always_comb
    begin
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_key_next    = res_key_reg;
        res_pay_next    = res_pay_reg;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_pay_next    = out_pay_reg;
        out_count_next  = out_count_reg;
        unique case (op)
            OP_LOAD:
            begin
                cmd_next        = cmd_code_t'(in_command);
                key_next        = (cmd_code_t'(in_command) == CMD_PREPEND) ? KEY_FIRST : in_key;
                pay_next        = in_payload;
                res_status_next = ST_OK;
                res_key_next    = '0;
                res_pay_next    = '0;
            end
            OP_SET_FULL:    res_status_next = ST_FULL;
            OP_SET_EMPTY:   res_status_next = ST_EMPTY;
            OP_SET_MISS:    res_status_next = ST_NOT_FOUND;
            OP_INIT_UP:     idx_next = IDX_W'(count_reg);
            OP_UP_MOVE:
            begin
                idx_next = idx_reg - IDX_W'(1);
                if ((cmd_reg == CMD_PREPEND) && (idx_reg == IDX_W'(1)))
                begin
                    key_next = prep_key;
                end
            end
            OP_PUT_NEW:     count_next = count_reg + CNT_W'(1);
            OP_INIT_SEARCH: idx_next = '0;
            OP_SEARCH_NEXT: idx_next = idx_reg + IDX_W'(1);
            OP_HIT:
            begin
                res_key_next = rd_data_reg.key;
                res_pay_next = rd_data_reg.payload;
            end
            OP_DN_MOVE:     idx_next = idx_reg + IDX_W'(1);
            OP_DN_DONE:     count_next = count_reg - CNT_W'(1);
            OP_EMIT:
            begin
                out_status_next = res_status_reg;
                out_key_next    = res_key_reg;
                out_pay_next    = res_pay_reg;
                out_count_next  = count_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        pay_reg        <= pay_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_key_reg    <= res_key_next;
        res_pay_reg    <= res_pay_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_pay_reg    <= out_pay_next;
        out_count_reg  <= out_count_next;
    end

    assign out_status  = out_status_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_pay_reg;
    assign out_count   = out_count_reg;

endmodule

`default_nettype wire

// File: sv/sorted_key_queue_top.sv
// ----------------------------------------------------------------------------
// sorted_key_queue_top
// Bounded priority queue of (key, payload) entries kept in ascending order.
// ----------------------------------------------------------------------------
// One request word is taken at a time; each gives exactly one response word.
// Inserts walk down from the top slot moving larger keys up, removals
// search up from slot 0 and then close the gap, one slot per cycle through
// the single read and single write port of the entry memory. Full-drop and
// empty cases skip the walk and go straight to the response.
// A new request is taken while the previous response still waits in the
// output register. The store needs no clearing after reset. The response
// interface must be built with COUNT_W = $clog2(CAPACITY + 1).
`default_nettype none

module sorted_key_queue_top import skq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    skq_req_if.sink    req,
    skq_rsp_if.source  rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    dp_op_t   op;
    dp_stat_t stat;
    logic [CNT_W-1:0] count;

    skq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .op        (op)
    );

    skq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_command  (req.command),
        .in_key      (req.in_key),
        .in_payload  (req.in_payload),
        .op          (op),
        .stat        (stat),
        .out_status  (rsp.status),
        .out_key     (rsp.out_key),
        .out_payload (rsp.out_payload),
        .out_count   (count)
    );

    assign rsp.entry_count = count;

endmodule

`default_nettype wire

// File: sv/skq_checker.sv
// ----------------------------------------------------------------------------
// skq_checker
// Port-level checks of the sorted key queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module skq_checker import skq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [STAT_W-1:0]             status,
    input wire logic signed [KEY_W-1:0]       out_key,
    input wire logic [PAY_W-1:0]              out_payload,
    input wire logic [$clog2(CAPACITY+1)-1:0] entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(out_key) && $stable(out_payload) && $stable(entry_count))

    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

    `ASSERT_IMPLY(a_full_count, clk, rst_n, out_valid && (status == ST_FULL), entry_count == CNT_W'(CAPACITY))

    `ASSERT_IMPLY(a_empty_count, clk, rst_n, out_valid && (status == ST_EMPTY), entry_count == '0)

    `ASSERT_IMPLY(a_fail_zero, clk, rst_n, out_valid && (status != ST_OK), (out_key == '0) && (out_payload == '0))

endmodule

bind sorted_key_queue_top skq_checker #(
    .CAPACITY (CAPACITY)
) u_skq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .status      (rsp.status),
    .out_key     (rsp.out_key),
    .out_payload (rsp.out_payload),
    .entry_count (rsp.entry_count)
);

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted key queue.
// ----------------------------------------------------------------------------
// A short table of directed commands covers the empty, full, not-found and
// saturating-prepend cases. Random command words follow, with the mix biased
// by phase so that the fill level swings between empty and full. A shadow
// copy of the sorted store predicts every response word, and responses are
// checked in order. Both channels idle in random bursts, except near the end.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import skq_pkg::*;

    localparam int CAP          = 16;
    localparam int COUNT_W      = $clog2(CAP + 1);
    localparam int NUM_DIRECTED = 25;
    localparam int RANDOM_ITEMS = 575;
    localparam int CALM_ITEMS   = 100;

    localparam logic signed [KEY_W-1:0] KEY_MAX = 16'sh7FFF;

    typedef struct packed {
        status_code_t            status;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
        logic [COUNT_W-1:0]      count;
    } queue_reply_t;

    typedef struct packed {
        cmd_code_t               cmd;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
        logic                    typed;
        queue_reply_t            reply;
    } stim_row_t;

    localparam queue_reply_t UNTYPED = '{ST_OK, 16'sd0, 32'h0, 5'd0};

    logic clk = 1'b0;
    logic rst_n;

    skq_req_if req ();
    skq_rsp_if #(.COUNT_W(COUNT_W)) rsp ();

    sorted_key_queue_top #(.CAPACITY(CAP)) uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow of the sorted store
    entry_t      slots [CAP];
    int unsigned held = 0;

    queue_reply_t pending_replies [$];
    int           error_count = 0;
    bit           calm = 1'b0;

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{CMD_REMOVE_HEAD, 16'sd0,  32'h0,        1'b1, '{ST_EMPTY, 16'sd0, 32'h0, 5'd0}},
        '{CMD_REMOVE_KEY,  16'sd5,  32'h0,        1'b1, '{ST_EMPTY, 16'sd0, 32'h0, 5'd0}},
        '{CMD_PREPEND,     16'sd0,  32'hFFFFFFFF, 1'b1, '{ST_OK,    16'sd0, 32'h0, 5'd1}},
        '{CMD_INSERT,      KEY_MAX, 32'h0,        1'b1, '{ST_OK,    16'sd0, 32'h0, 5'd2}},
        '{CMD_INSERT,      KEY_MIN, 32'hA5A5A5A5, 1'b1, '{ST_OK,    16'sd0, 32'h0, 5'd3}},
        '{CMD_INSERT,      16'sd1,  32'h00000011, 1'b0, UNTYPED},
        '{CMD_REMOVE_KEY,  16'sd7,  32'h0,        1'b1, '{ST_NOT_FOUND, 16'sd0, 32'h0, 5'd4}},
        '{CMD_PREPEND,     -16'sd1, 32'h5A5A5A5A, 1'b0, UNTYPED},
        '{CMD_REMOVE_HEAD, KEY_MAX, 32'hFFFFFFFF, 1'b0, UNTYPED},
        '{CMD_REMOVE_KEY,  16'sd1,  32'h0,        1'b0, UNTYPED},
        '{CMD_INSERT,      16'sd0,  32'h00000001, 1'b0, UNTYPED},
        '{CMD_INSERT,      -16'sd1, 32'h80000000, 1'b0, UNTYPED},
        '{CMD_INSERT,      16'sd100, 32'h12345678, 1'b0, UNTYPED},
        '{CMD_INSERT,      -16'sd100, 32'h87654321, 1'b0, UNTYPED},
        '{CMD_INSERT,      16'sd1,  32'h00000022, 1'b0, UNTYPED},
        '{CMD_INSERT,      16'sd1,  32'h00000033, 1'b0, UNTYPED},
        '{CMD_INSERT,      16'sh7FFE, 32'hDEADBEEF, 1'b0, UNTYPED},
        '{CMD_INSERT,      -16'sd32767, 32'hCAFEF00D, 1'b0, UNTYPED},
        '{CMD_INSERT,      16'sd42, 32'h0000FFFF, 1'b0, UNTYPED},
        '{CMD_INSERT,      16'sd42, 32'hFFFF0000, 1'b0, UNTYPED},
        '{CMD_INSERT,      -16'sd5, 32'h55555555, 1'b0, UNTYPED},
        '{CMD_INSERT,      16'sd7,  32'hAAAAAAAA, 1'b0, UNTYPED},
        '{CMD_INSERT,      16'sd2,  32'h0F0F0F0F, 1'b0, UNTYPED},
        '{CMD_INSERT,      16'sd3,  32'h1, 1'b1, '{ST_FULL, 16'sd0, 32'h0, 5'd16}},
        '{CMD_PREPEND,     16'sd3,  32'h2, 1'b1, '{ST_FULL, 16'sd0, 32'h0, 5'd16}}
    };

    // Apply one command to the shadow store and return the response it gives.
    function automatic queue_reply_t predict_reply(cmd_code_t cmd,
                                                   logic signed [KEY_W-1:0] key,
                                                   logic [PAY_W-1:0] payload);
        queue_reply_t            reply;
        int unsigned             pos;
        logic signed [KEY_W-1:0] head;
        reply = '{ST_OK, 16'sd0, 32'h0, 5'd0};
        pos   = 0;
        case (cmd)
            CMD_INSERT, CMD_PREPEND:
            begin
                if (held >= CAP)
                    reply.status = ST_FULL;
                else
                begin
                    if (cmd == CMD_INSERT)
                    begin
                        // Land after every equal key
                        while (pos < held && $signed(slots[pos].key) <= key)
                            pos++;
                    end
                    else
                    begin
                        head = slots[0].key;
                        if (held == 0)
                            key = KEY_FIRST;
                        else if (head == KEY_MIN)
                            key = KEY_MIN;
                        else
                            key = head - 16'sd1;
                    end
                    for (int i = held; i > pos; i--)
                        slots[i] = slots[i-1];
                    slots[pos].key     = key;
                    slots[pos].payload = payload;
                    held++;
                end
            end
            default:
            begin
                if (held == 0)
                    reply.status = ST_EMPTY;
                else
                begin
                    if (cmd == CMD_REMOVE_KEY)
                    begin
                        while (pos < held && $signed(slots[pos].key) != key)
                            pos++;
                    end
                    if (pos == held)
                        reply.status = ST_NOT_FOUND;
                    else
                    begin
                        reply.key     = slots[pos].key;
                        reply.payload = slots[pos].payload;
                        for (int i = pos; i + 1 < held; i++)
                            slots[i] = slots[i+1];
                        held--;
                    end
                end
            end
        endcase
        reply.count = COUNT_W'(held);
        return reply;
    endfunction

    // Mostly small keys so that equal keys and keyed hits are common.
    function automatic logic signed [KEY_W-1:0] random_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return KEY_W'($signed($urandom_range(0, 16)) - 8);
        else if (r < 70)
            return KEY_MIN;
        else if (r < 75)
            return KEY_MAX;
        else
            return KEY_W'($urandom);
    endfunction

    function automatic void check_field(string name, logic [PAY_W-1:0] expected,
                                        logic [PAY_W-1:0] actual);
        if (expected !== actual)
        begin
            $error("%s: expected %0h, actual %0h", name, expected, actual);
            error_count++;
        end
    endfunction

    task automatic send_word(cmd_code_t cmd, logic signed [KEY_W-1:0] key,
                             logic [PAY_W-1:0] payload, logic typed,
                             queue_reply_t typed_reply);
        queue_reply_t predicted;
        @(negedge clk);
        req.valid      <= 1'b1;
        req.command    <= cmd;
        req.in_key     <= key;
        req.in_payload <= payload;
        do
            @(posedge clk);
        while (!req.ready);
        predicted = predict_reply(cmd, key, payload);
        pending_replies.push_back(typed ? typed_reply : predicted);
    endtask

    task automatic idle_cycles(int unsigned n);
        @(negedge clk);
        req.valid <= 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    // Response side: stall in random bursts
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        rsp.ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left != 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        queue_reply_t exp_reply;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("response word with none expected: status %0d key %0h",
                       rsp.status, rsp.out_key);
                error_count++;
            end
            else
            begin
                exp_reply = pending_replies.pop_front();
                check_field("status", PAY_W'(exp_reply.status), PAY_W'(rsp.status));
                check_field("out_key", PAY_W'($unsigned(exp_reply.key)),
                            PAY_W'($unsigned(rsp.out_key)));
                check_field("out_payload", exp_reply.payload, rsp.out_payload);
                check_field("entry_count", PAY_W'(exp_reply.count),
                            PAY_W'(rsp.entry_count));
            end
        end
    end

    initial
    begin
        cmd_code_t               cmd;
        logic signed [KEY_W-1:0] key;
        int unsigned             bias;
        int unsigned             ins_w;
        int unsigned             rh_w;
        int unsigned             rk_w;
        int unsigned             r;
        bias           = 2;
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.command    = CMD_INSERT;
        req.in_key     = '0;
        req.in_payload = '0;
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if ($urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 13));
            send_word(directed_rows[i].cmd, directed_rows[i].key,
                      directed_rows[i].payload, directed_rows[i].typed,
                      directed_rows[i].reply);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Swing the fill level between drain, fill and balanced phases
            if (n % 40 == 0)
                bias = $urandom_range(0, 2);
            case (bias)
                0:       begin ins_w = 20; rh_w = 35; rk_w = 35; end
                1:       begin ins_w = 55; rh_w = 10; rk_w = 15; end
                default: begin ins_w = 35; rh_w = 20; rk_w = 30; end
            endcase
            r = $urandom_range(0, 99);
            if (r < ins_w)
                cmd = CMD_INSERT;
            else if (r < ins_w + rh_w)
                cmd = CMD_REMOVE_HEAD;
            else if (r < ins_w + rh_w + rk_w)
                cmd = CMD_REMOVE_KEY;
            else
                cmd = CMD_PREPEND;

            key = random_key();
            if (cmd == CMD_REMOVE_KEY && held != 0 && $urandom_range(0, 9) < 7)
                key = slots[$urandom_range(0, held - 1)].key;

            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            // Hold off once until every response has drained
            if (n == RANDOM_ITEMS / 2)
            begin
                idle_cycles($urandom_range(1, 13));
                while (pending_replies.size() != 0)
                    @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 13));

            send_word(cmd, key, $urandom, 1'b0, UNTYPED);
        end

        @(negedge clk);
        req.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (CAP + 8)
            @(posedge clk);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
